@@ design/dhfk_pkg.sv @@
// Shared types, constants and helpers for the DH forward kinematics core.
// Used by dhfk_cordic, dhfk_link and the top level.
`timescale 1ns / 1ps
package dhfk_pkg;

   localparam int NUM_JOINTS      = 6;
   localparam int JOINT_COUNT_MAX = 6;

   // CORDIC
   localparam int CORDIC_STEPS    = 18;
   localparam int STEPS_PER_STAGE = 3;
   localparam int CORDIC_STAGES   = CORDIC_STEPS / STEPS_PER_STAGE;
   // wrap + fold + iteration stages + round
   localparam int CORDIC_LAT      = CORDIC_STAGES + 3;

   localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
   localparam logic signed [33:0] TWO_PI_Q30  = 34'sd6746518852;
   localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
   localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;

   localparam logic signed [33:0] ATAN_Q30 [CORDIC_STEPS] = '{
      34'sd843314856, 34'sd497837829, 34'sd263043836, 34'sd133525158,
      34'sd67021686,  34'sd33543515,  34'sd16775850,  34'sd8388437,
      34'sd4194282,   34'sd2097149,   34'sd1048575,   34'sd524287,
      34'sd262143,    34'sd131071,    34'sd65535,     34'sd32767,
      34'sd16383,     34'sd8191
   };

   // Link geometry, Q16 metres
   localparam logic signed [33:0] LINK_A_Q16 [NUM_JOINTS] = '{
      34'sd0, -34'sd27853, -34'sd25703, 34'sd0, 34'sd0, 34'sd0
   };
   localparam logic signed [33:0] LINK_D_Q16 [NUM_JOINTS] = '{
      34'sd10650, 34'sd0, 34'sd0, 34'sd8736, 34'sd6534, 34'sd6527
   };
   // cos / sin of the twist angles
   localparam logic signed [1:0] TWIST_C [NUM_JOINTS] = '{
      2'sd0, 2'sd1, 2'sd1, 2'sd0, 2'sd0, 2'sd1
   };
   localparam logic signed [1:0] TWIST_S [NUM_JOINTS] = '{
      2'sd1, 2'sd0, 2'sd0, 2'sd1, -2'sd1, 2'sd0
   };

   // CSR
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCALE  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_JOINTS = 2'd1;
   localparam logic [15:0] SCALE_RESET = 16'd4096;

   typedef logic signed [17:0] rot_type;   // Q1.16
   typedef logic signed [25:0] pos_type;   // Q16 metres, wide
   typedef logic signed [20:0] link_type;  // scaled link length

   typedef struct packed {
      logic       valid;
      logic [2:0] n;
   } ctl_type;

   typedef struct packed {
      logic signed [17:0] c;
      logic signed [17:0] s;
      logic signed [20:0] px;
      logic signed [20:0] py;
   } joint_type;

   // round half up by sh bits, clamp to [-1.0, 1.0] Q16
   function automatic rot_type round_clamp(input logic signed [47:0] v,
                                           input int unsigned sh);
      logic signed [47:0] r;
      r = (v + (48'sd1 <<< (sh - 1))) >>> sh;
      if (r > 48'sd65536)
         return 18'sd65536;
      else if (r < -48'sd65536)
         return -18'sd65536;
      return r[17:0];
   endfunction

   // multiply by a twist term of -1, 0 or 1
   function automatic logic signed [39:0] twist_term(input logic signed [39:0] v,
                                                     input logic signed [1:0] t);
      if (t > 2'sd0)
         return v;
      else if (t < 2'sd0)
         return -v;
      return '0;
   endfunction

endpackage

@@ design/dhfk_cordic.sv @@
// One sine/cosine lane: angle wrap, quadrant fold, pipelined CORDIC, rounding.
// Depends on dhfk_pkg.
`timescale 1ns / 1ps
module dhfk_cordic (
   input  logic                clock,
   input  logic                en,
   input  logic signed [17:0]  angle,
   output dhfk_pkg::rot_type   cos_out,
   output dhfk_pkg::rot_type   sin_out
);
   localparam int NS = dhfk_pkg::CORDIC_STAGES;
   localparam int PS = dhfk_pkg::STEPS_PER_STAGE;

   logic signed [33:0] za;
   logic signed [33:0] zw_in;
   logic signed [33:0] zw_ff;
   logic signed [33:0] zf_in;
   logic               neg_in;

   logic signed [33:0] x_ff [NS+1];
   logic signed [33:0] y_ff [NS+1];
   logic signed [33:0] z_ff [NS+1];
   logic               neg_ff [NS+1];
   logic signed [33:0] x_in [NS];
   logic signed [33:0] y_in [NS];
   logic signed [33:0] z_in [NS];

   logic signed [33:0] xn, yn;
   dhfk_pkg::rot_type  cos_in, sin_in, cos_ff, sin_ff;

   // wrap into [-pi, pi]; one pass covers the full input range
   always_comb begin
      za    = $signed({angle, 16'b0});
      zw_in = za;
      if (za > dhfk_pkg::PI_Q30)
         zw_in = za - dhfk_pkg::TWO_PI_Q30;
      else if (za < -dhfk_pkg::PI_Q30)
         zw_in = za + dhfk_pkg::TWO_PI_Q30;
   end

   // fold into [-pi/2, pi/2], negate results at the end
   always_comb begin
      zf_in  = zw_ff;
      neg_in = 1'b0;
      if (zw_ff > dhfk_pkg::HALF_PI_Q30) begin
         zf_in  = zw_ff - dhfk_pkg::PI_Q30;
         neg_in = 1'b1;
      end else if (zw_ff < -dhfk_pkg::HALF_PI_Q30) begin
         zf_in  = zw_ff + dhfk_pkg::PI_Q30;
         neg_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         zw_ff     <= zw_in;
         x_ff[0]   <= dhfk_pkg::GAIN_Q30;
         y_ff[0]   <= '0;
         z_ff[0]   <= zf_in;
         neg_ff[0] <= neg_in;
      end
   end

   for (genvar g = 0; g < NS; g++) begin : g_stage
      always_comb begin : step
         logic signed [33:0] xt, yt, zt, tx;
         xt = x_ff[g];
         yt = y_ff[g];
         zt = z_ff[g];
         tx = xt;
         for (int j = 0; j < PS; j++) begin
            if (zt >= 0) begin
               tx = xt - (yt >>> (g * PS + j));
               yt = yt + (xt >>> (g * PS + j));
               zt = zt - dhfk_pkg::ATAN_Q30[g * PS + j];
            end else begin
               tx = xt + (yt >>> (g * PS + j));
               yt = yt - (xt >>> (g * PS + j));
               zt = zt + dhfk_pkg::ATAN_Q30[g * PS + j];
            end
            xt = tx;
         end
         x_in[g] = xt;
         y_in[g] = yt;
         z_in[g] = zt;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[g+1]   <= x_in[g];
            y_ff[g+1]   <= y_in[g];
            z_ff[g+1]   <= z_in[g];
            neg_ff[g+1] <= neg_ff[g];
         end
      end
   end

   always_comb begin
      xn     = neg_ff[NS] ? -x_ff[NS] : x_ff[NS];
      yn     = neg_ff[NS] ? -y_ff[NS] : y_ff[NS];
      cos_in = dhfk_pkg::round_clamp(48'(xn), 14);
      sin_in = dhfk_pkg::round_clamp(48'(yn), 14);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cos_ff <= cos_in;
         sin_ff <= sin_in;
      end
   end

   assign cos_out = cos_ff;
   assign sin_out = sin_ff;

   // z_ff of the last stage is the residual angle, unused past here
   logic unused_z;
   assign unused_z = ^z_ff[NS];
endmodule

@@ design/dhfk_link.sv @@
// One chaining step F * T_j: multiplier stage, then sum/round/clamp stage.
// Depends on dhfk_pkg.
`timescale 1ns / 1ps
module dhfk_link (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  dhfk_pkg::ctl_type             ctl_in,
   input  dhfk_pkg::joint_type [5:0]     joints_in,
   input  dhfk_pkg::rot_type             fr_in [3][3],
   input  dhfk_pkg::pos_type             fp_in [3],
   input  dhfk_pkg::joint_type           cur,
   input  dhfk_pkg::link_type            link_d,
   input  logic signed [1:0]             twist_c,
   input  logic signed [1:0]             twist_s,
   input  logic                          active,
   output dhfk_pkg::ctl_type             ctl_out,
   output dhfk_pkg::joint_type [5:0]     joints_out,
   output dhfk_pkg::rot_type             fr_out [3][3],
   output dhfk_pkg::pos_type             fp_out [3]
);
   dhfk_pkg::ctl_type         ctl_a_ff, ctl_b_ff;
   dhfk_pkg::joint_type [5:0] joints_a_ff, joints_b_ff;
   logic                      act_a_ff;
   dhfk_pkg::rot_type         fr_a_ff [3][3];
   dhfk_pkg::pos_type         fp_a_ff [3];
   logic signed [35:0]        m0_ff [3];   // fr0 * c
   logic signed [35:0]        m1_ff [3];   // fr1 * s
   logic signed [35:0]        m2_ff [3];   // fr0 * s
   logic signed [35:0]        m3_ff [3];   // fr1 * c
   logic signed [38:0]        q_ff [3][3]; // fr * p

   dhfk_pkg::rot_type         fr_b_in [3][3];
   dhfk_pkg::pos_type         fp_b_in [3];
   dhfk_pkg::rot_type         fr_b_ff [3][3];
   dhfk_pkg::pos_type         fp_b_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_a_ff <= '0;
      end else if (en) begin
         ctl_a_ff <= ctl_in;
      end
      if (en) begin
         joints_a_ff <= joints_in;
         act_a_ff    <= active;
         fr_a_ff     <= fr_in;
         fp_a_ff     <= fp_in;
         for (int r = 0; r < 3; r++) begin
            m0_ff[r]   <= fr_in[r][0] * cur.c;
            m1_ff[r]   <= fr_in[r][1] * cur.s;
            m2_ff[r]   <= fr_in[r][0] * cur.s;
            m3_ff[r]   <= fr_in[r][1] * cur.c;
            q_ff[r][0] <= fr_in[r][0] * cur.px;
            q_ff[r][1] <= fr_in[r][1] * cur.py;
            q_ff[r][2] <= fr_in[r][2] * link_d;
         end
      end
   end

   always_comb begin : sums
      logic signed [39:0] hi, s0, s1, s2, dif;
      logic signed [41:0] acc;
      hi  = '0;
      s0  = '0;
      s1  = '0;
      s2  = '0;
      dif = '0;
      acc = '0;
      for (int r = 0; r < 3; r++) begin
         hi  = 40'(fr_a_ff[r][2]) <<< 16;
         s0  = 40'(m0_ff[r]) + 40'(m1_ff[r]);
         dif = 40'(m3_ff[r]) - 40'(m2_ff[r]);
         s1  = dhfk_pkg::twist_term(dif, twist_c) + dhfk_pkg::twist_term(hi, twist_s);
         s2  = dhfk_pkg::twist_term(-dif, twist_s) + dhfk_pkg::twist_term(hi, twist_c);
         acc = 42'(q_ff[r][0]) + 42'(q_ff[r][1]) + 42'(q_ff[r][2]);
         if (act_a_ff) begin
            fr_b_in[r][0] = dhfk_pkg::round_clamp(48'(s0), 16);
            fr_b_in[r][1] = dhfk_pkg::round_clamp(48'(s1), 16);
            fr_b_in[r][2] = dhfk_pkg::round_clamp(48'(s2), 16);
            fp_b_in[r]    = 26'((acc + 42'sd32768) >>> 16) + fp_a_ff[r];
         end else begin
            fr_b_in[r] = fr_a_ff[r];
            fp_b_in[r] = fp_a_ff[r];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_b_ff <= '0;
      end else if (en) begin
         ctl_b_ff <= ctl_a_ff;
      end
      if (en) begin
         joints_b_ff <= joints_a_ff;
         fr_b_ff     <= fr_b_in;
         fp_b_ff     <= fp_b_in;
      end
   end

   assign ctl_out    = ctl_b_ff;
   assign joints_out = joints_b_ff;
   assign fr_out     = fr_b_ff;
   assign fp_out     = fp_b_ff;
endmodule

@@ design/dh_forward_kinematics_6dof_core.sv @@
// Top level of the six-axis Denavit-Hartenberg forward kinematics core.
// Depends on dhfk_pkg, dhfk_cordic and dhfk_link.
`timescale 1ns / 1ps
// Fully pipelined pose engine: one request per clock while the pipe is not held;
// each pose leaves through the result register in the order of the requests.
// Six CORDIC lanes (wrap, fold, 18 rotations at 3 per stage, round) produce
// sin/cos for all joints at once; two stages turn them into per-joint a*cos,
// a*sin; then each further joint is one two-stage matrix-product step
// (multipliers, then sums/round/clamp). Joints past joint_count pass the frame
// through unchanged, so latency does not depend on joint_count. The whole pipe
// holds when the result register is full and not taken. Write scale_factor /
// joint_count only while idle.
module dh_forward_kinematics_6dof_core #(
   parameter int JOINT_COUNT_MAX = dhfk_pkg::JOINT_COUNT_MAX
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [17:0]                    req_joint_angle_1,
   input  logic signed [17:0]                    req_joint_angle_2,
   input  logic signed [17:0]                    req_joint_angle_3,
   input  logic signed [17:0]                    req_joint_angle_4,
   input  logic signed [17:0]                    req_joint_angle_5,
   input  logic signed [17:0]                    req_joint_angle_6,
   // result channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [23:0]                    rsp_pos_x,
   output logic signed [23:0]                    rsp_pos_y,
   output logic signed [23:0]                    rsp_pos_z,
   output logic signed [17:0]                    rsp_rot_00,
   output logic signed [17:0]                    rsp_rot_01,
   output logic signed [17:0]                    rsp_rot_02,
   output logic signed [17:0]                    rsp_rot_10,
   output logic signed [17:0]                    rsp_rot_11,
   output logic signed [17:0]                    rsp_rot_12,
   output logic signed [17:0]                    rsp_rot_20,
   output logic signed [17:0]                    rsp_rot_21,
   output logic signed [17:0]                    rsp_rot_22,
   // register writes
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [dhfk_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [15:0]                           csr_data
);
   localparam int NJ  = dhfk_pkg::NUM_JOINTS;
   localparam int LAT = dhfk_pkg::CORDIC_LAT;
   localparam int FIN = JOINT_COUNT_MAX - 1;

   // global advance: every pipeline stage moves unless the result is stuck
   logic en;
   logic rsp_valid_ff;
   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;
   assign csr_ready = 1'b1;

   // ---------------- configuration ----------------
   logic [15:0] scale_ff;
   logic [2:0]  jcount_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff  <= dhfk_pkg::SCALE_RESET;
         jcount_ff <= 3'(JOINT_COUNT_MAX);
      end else if (csr_valid) begin
         unique case (csr_index)
            dhfk_pkg::CSR_SCALE:  scale_ff  <= csr_data;
            dhfk_pkg::CSR_JOINTS: jcount_ff <= csr_data[2:0];
            default: ;
         endcase
      end
   end

   // scaled link lengths, refreshed every cycle from the scale register
   dhfk_pkg::link_type a_sc_ff [NJ];
   dhfk_pkg::link_type d_sc_ff [NJ];

   always_ff @(posedge clock) begin : scale_links
      logic signed [33:0] pa, pd;
      pa = '0;
      pd = '0;
      for (int j = 0; j < NJ; j++) begin
         pa = dhfk_pkg::LINK_A_Q16[j] * 34'($signed({1'b0, scale_ff}));
         pd = dhfk_pkg::LINK_D_Q16[j] * 34'($signed({1'b0, scale_ff}));
         a_sc_ff[j] <= 21'((pa + 34'sd2048) >>> 12);
         d_sc_ff[j] <= 21'((pd + 34'sd2048) >>> 12);
      end
   end

   // ---------------- input register ----------------
   logic signed [17:0] ang_in [NJ];
   logic signed [17:0] ang_ff [NJ];
   logic [2:0]         n_in;
   dhfk_pkg::ctl_type  ctl_in_ff;

   assign ang_in[0] = req_joint_angle_1;
   assign ang_in[1] = req_joint_angle_2;
   assign ang_in[2] = req_joint_angle_3;
   assign ang_in[3] = req_joint_angle_4;
   assign ang_in[4] = req_joint_angle_5;
   assign ang_in[5] = req_joint_angle_6;

   // zero means one joint, too many means all
   always_comb begin
      if (jcount_ff == 3'd0)
         n_in = 3'd1;
      else if (jcount_ff > 3'(JOINT_COUNT_MAX))
         n_in = 3'(JOINT_COUNT_MAX);
      else
         n_in = jcount_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_in_ff <= '0;
      end else if (en) begin
         ctl_in_ff.valid <= req_valid;
         ctl_in_ff.n     <= n_in;
      end
      if (en) begin
         ang_ff <= ang_in;
      end
   end

   // ---------------- sin/cos lanes ----------------
   dhfk_pkg::rot_type c_lane [NJ];
   dhfk_pkg::rot_type s_lane [NJ];

   for (genvar j = 0; j < NJ; j++) begin : g_lane
      dhfk_cordic u_cordic (
         .clock   (clock),
         .en      (en),
         .angle   (ang_ff[j]),
         .cos_out (c_lane[j]),
         .sin_out (s_lane[j])
      );
   end

   dhfk_pkg::ctl_type ctl_c_ff [LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAT; i++)
            ctl_c_ff[i] <= '0;
      end else if (en) begin
         ctl_c_ff[0] <= ctl_in_ff;
         for (int i = 1; i < LAT; i++)
            ctl_c_ff[i] <= ctl_c_ff[i-1];
      end
   end

   // ---------------- per-joint a*cos, a*sin ----------------
   dhfk_pkg::ctl_type         ctl_d1_ff, ctl_d2_ff;
   logic signed [38:0]        prod_c_ff [NJ];
   logic signed [38:0]        prod_s_ff [NJ];
   dhfk_pkg::rot_type         c_d1_ff [NJ];
   dhfk_pkg::rot_type         s_d1_ff [NJ];
   dhfk_pkg::joint_type [5:0] joints_d2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_d1_ff <= '0;
         ctl_d2_ff <= '0;
      end else if (en) begin
         ctl_d1_ff <= ctl_c_ff[LAT-1];
         ctl_d2_ff <= ctl_d1_ff;
      end
      if (en) begin
         for (int j = 0; j < NJ; j++) begin
            prod_c_ff[j]       <= a_sc_ff[j] * c_lane[j];
            prod_s_ff[j]       <= a_sc_ff[j] * s_lane[j];
            c_d1_ff[j]         <= c_lane[j];
            s_d1_ff[j]         <= s_lane[j];
            joints_d2_ff[j].c  <= c_d1_ff[j];
            joints_d2_ff[j].s  <= s_d1_ff[j];
            joints_d2_ff[j].px <= 21'((prod_c_ff[j] + 39'sd32768) >>> 16);
            joints_d2_ff[j].py <= 21'((prod_s_ff[j] + 39'sd32768) >>> 16);
         end
      end
   end

   // ---------------- frame chain ----------------
   dhfk_pkg::rot_type         fr_w [JOINT_COUNT_MAX][3][3];
   dhfk_pkg::pos_type         fp_w [JOINT_COUNT_MAX][3];
   dhfk_pkg::ctl_type         ctl_w [JOINT_COUNT_MAX];
   dhfk_pkg::joint_type [5:0] jd_w [JOINT_COUNT_MAX];

   // base frame is T1 itself
   always_comb begin : base_frame
      logic signed [39:0] c0, s0;
      c0 = 40'(joints_d2_ff[0].c);
      s0 = 40'(joints_d2_ff[0].s);
      fr_w[0][0][0] = joints_d2_ff[0].c;
      fr_w[0][0][1] = 18'(dhfk_pkg::twist_term(-s0, dhfk_pkg::TWIST_C[0]));
      fr_w[0][0][2] = 18'(dhfk_pkg::twist_term(s0, dhfk_pkg::TWIST_S[0]));
      fr_w[0][1][0] = joints_d2_ff[0].s;
      fr_w[0][1][1] = 18'(dhfk_pkg::twist_term(c0, dhfk_pkg::TWIST_C[0]));
      fr_w[0][1][2] = 18'(dhfk_pkg::twist_term(-c0, dhfk_pkg::TWIST_S[0]));
      fr_w[0][2][0] = '0;
      fr_w[0][2][1] = 18'(dhfk_pkg::twist_term(40'sd65536, dhfk_pkg::TWIST_S[0]));
      fr_w[0][2][2] = 18'(dhfk_pkg::twist_term(40'sd65536, dhfk_pkg::TWIST_C[0]));
      fp_w[0][0]    = 26'(joints_d2_ff[0].px);
      fp_w[0][1]    = 26'(joints_d2_ff[0].py);
      fp_w[0][2]    = 26'(d_sc_ff[0]);
   end

   assign ctl_w[0] = ctl_d2_ff;
   assign jd_w[0]  = joints_d2_ff;

   for (genvar k = 1; k < JOINT_COUNT_MAX; k++) begin : g_link
      dhfk_link u_link (
         .clock      (clock),
         .reset      (reset),
         .en         (en),
         .ctl_in     (ctl_w[k-1]),
         .joints_in  (jd_w[k-1]),
         .fr_in      (fr_w[k-1]),
         .fp_in      (fp_w[k-1]),
         .cur        (jd_w[k-1][k]),
         .link_d     (d_sc_ff[k]),
         .twist_c    (dhfk_pkg::TWIST_C[k]),
         .twist_s    (dhfk_pkg::TWIST_S[k]),
         .active     (ctl_w[k-1].n > 3'(k)),
         .ctl_out    (ctl_w[k]),
         .joints_out (jd_w[k]),
         .fr_out     (fr_w[k]),
         .fp_out     (fp_w[k])
      );
   end

   // ---------------- result register ----------------
   logic signed [23:0] pos_sat [3];
   logic signed [23:0] pos_ff [3];
   dhfk_pkg::rot_type  rot_ff [3][3];

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         if (fp_w[FIN][r] > 26'sd8388607)
            pos_sat[r] = 24'sd8388607;
         else if (fp_w[FIN][r] < -26'sd8388608)
            pos_sat[r] = -24'sd8388608;
         else
            pos_sat[r] = fp_w[FIN][r][23:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= ctl_w[FIN].valid;
      end
      if (en) begin
         pos_ff <= pos_sat;
         rot_ff <= fr_w[FIN];
      end
   end

   // joint data and count are spent once the last frame is formed
   logic unused_tail;
   assign unused_tail = ^{jd_w[FIN], ctl_w[FIN].n};

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_pos_x  = pos_ff[0];
   assign rsp_pos_y  = pos_ff[1];
   assign rsp_pos_z  = pos_ff[2];
   assign rsp_rot_00 = rot_ff[0][0];
   assign rsp_rot_01 = rot_ff[0][1];
   assign rsp_rot_02 = rot_ff[0][2];
   assign rsp_rot_10 = rot_ff[1][0];
   assign rsp_rot_11 = rot_ff[1][1];
   assign rsp_rot_12 = rot_ff[1][2];
   assign rsp_rot_20 = rot_ff[2][0];
   assign rsp_rot_21 = rot_ff[2][1];
   assign rsp_rot_22 = rot_ff[2][2];
endmodule

@@ tb/sv/tb_dh_forward_kinematics_6dof_core.sv @@
// Self-checking testbench for dh_forward_kinematics_6dof_core: poses from directed and random joint angles
// are compared field by field against a fixed-point DH chain computed in the bench.
// Depends on dhfk_pkg and the core RTL.
`timescale 1ns / 1ps

class pose_scoreboard;
   typedef struct {
      logic signed [23:0] pos [3];
      logic signed [17:0] rot [9];
   } pose_type;

   pose_type pending [$];
   int    errors;
   logic [15:0] scale;
   logic [2:0]  joints;

   localparam longint PI_Q = 64'sd3373259426;
   localparam longint HPI_Q = 64'sd1686629713;
   longint atan_tab [18] = '{843314856, 497837829, 263043836, 133525158, 67021686,
      33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
      131071, 65535, 32767, 16383, 8191};
   longint len_a [6] = '{0, -27853, -25703, 0, 0, 0};
   longint len_d [6] = '{10650, 0, 0, 8736, 6534, 6527};
   longint tw_c [6] = '{0, 1, 1, 0, 0, 1};
   longint tw_s [6] = '{1, 0, 0, 1, -1, 0};

   function new();
      errors = 0;
      scale  = dhfk_pkg::SCALE_RESET;
      joints = 3'(dhfk_pkg::JOINT_COUNT_MAX);
   endfunction

   // >>> on longint is arithmetic, i.e. a floor shift
   static function longint rnd16(longint v, int sh);
      return (v + (64'sd1 <<< (sh - 1))) >>> sh;
   endfunction

   static function longint lim(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function void trig(longint ang, output longint c, output longint s);
      longint z, x, y, t;
      bit flip;
      z = ang * 65536;
      x = 652032874;
      y = 0;
      flip = 0;
      while (z > PI_Q) z -= 2 * PI_Q;
      while (z < -PI_Q) z += 2 * PI_Q;
      if (z > HPI_Q) begin z -= PI_Q; flip = 1; end
      else if (z < -HPI_Q) begin z += PI_Q; flip = 1; end
      for (int i = 0; i < 18; i++) begin
         if (z >= 0) begin
            t = x - (y >>> i); y = y + (x >>> i); z -= atan_tab[i];
         end else begin
            t = x + (y >>> i); y = y - (x >>> i); z += atan_tab[i];
         end
         x = t;
      end
      if (flip) begin x = -x; y = -y; end
      c = lim(rnd16(x, 14), -65536, 65536);
      s = lim(rnd16(y, 14), -65536, 65536);
   endfunction

   // note an accepted request and queue the pose it must produce
   function void note_request(logic signed [17:0] ang [6]);
      longint fr [3][3], fp [3], tr [3][3], tp [3], nr [3][3], np [3];
      longint c, s, a, d, acc, sum;
      int n;
      pose_type p;
      n = joints < 1 ? 1 : (joints > 6 ? 6 : int'(joints));
      for (int j = 0; j < n; j++) begin
         a = (len_a[j] * longint'(scale) + 2048) >>> 12;
         d = (len_d[j] * longint'(scale) + 2048) >>> 12;
         trig(longint'(ang[j]), c, s);
         tr[0] = '{c, -s * tw_c[j], s * tw_s[j]};
         tr[1] = '{s, c * tw_c[j], -c * tw_s[j]};
         tr[2] = '{0, tw_s[j] * 65536, tw_c[j] * 65536};
         tp = '{rnd16(a * c, 16), rnd16(a * s, 16), d};
         if (j == 0) begin
            fr = tr; fp = tp;
         end else begin
            for (int r = 0; r < 3; r++) begin
               acc = 0;
               for (int k = 0; k < 3; k++) begin
                  sum = 0;
                  for (int m = 0; m < 3; m++) sum += fr[r][m] * tr[m][k];
                  nr[r][k] = lim(rnd16(sum, 16), -65536, 65536);
                  acc += fr[r][k] * tp[k];
               end
               np[r] = rnd16(acc, 16) + fp[r];
            end
            fr = nr; fp = np;
         end
      end
      for (int r = 0; r < 3; r++) begin
         p.pos[r] = 24'(lim(fp[r], -8388608, 8388607));
         for (int k = 0; k < 3; k++) p.rot[r * 3 + k] = 18'(fr[r][k]);
      end
      pending = {pending, p};
   endfunction

   function void report(string what);
      $display("mismatch @%0t: %s", $realtime, what);
      errors++;
   endfunction

   function void check_pose(logic signed [23:0] pos [3], logic signed [17:0] rot [9]);
      pose_type e;
      if (pending.size() == 0) begin
         report("pose with no request outstanding");
         return;
      end
      e = pending.pop_front();
      for (int i = 0; i < 3; i++)
         if (pos[i] !== e.pos[i])
            report($sformatf("pos[%0d] got %0d want %0d", i, pos[i], e.pos[i]));
      for (int i = 0; i < 9; i++)
         if (rot[i] !== e.rot[i])
            report($sformatf("rot_%0d%0d got %0d want %0d", i / 3, i % 3, rot[i], e.rot[i]));
   endfunction
endclass

module tb_dh_forward_kinematics_6dof_core;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0, req_ready;
   logic signed [17:0] req_ang [6];
   logic rsp_valid, rsp_ready = 0;
   logic signed [23:0] rsp_pos [3];
   logic signed [17:0] rsp_rot [9];
   logic csr_valid = 0, csr_ready;
   logic [dhfk_pkg::CSR_INDEX_W-1:0] csr_index = dhfk_pkg::CSR_SCALE;
   logic [15:0] csr_data = 0;

   pose_scoreboard sb = new();
   bit long_stall = 0;     // receiver holds off entirely while set

   initial for (int i = 0; i < 6; i++) req_ang[i] = 0;

   always #5 clock = ~clock;

   dh_forward_kinematics_6dof_core i_dut (
      .clock, .reset,
      .req_valid, .req_ready,
      .req_joint_angle_1(req_ang[0]), .req_joint_angle_2(req_ang[1]),
      .req_joint_angle_3(req_ang[2]), .req_joint_angle_4(req_ang[3]),
      .req_joint_angle_5(req_ang[4]), .req_joint_angle_6(req_ang[5]),
      .rsp_valid, .rsp_ready,
      .rsp_pos_x(rsp_pos[0]), .rsp_pos_y(rsp_pos[1]), .rsp_pos_z(rsp_pos[2]),
      .rsp_rot_00(rsp_rot[0]), .rsp_rot_01(rsp_rot[1]), .rsp_rot_02(rsp_rot[2]),
      .rsp_rot_10(rsp_rot[3]), .rsp_rot_11(rsp_rot[4]), .rsp_rot_12(rsp_rot[5]),
      .rsp_rot_20(rsp_rot[6]), .rsp_rot_21(rsp_rot[7]), .rsp_rot_22(rsp_rot[8]),
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   // Scoreboard hooks at the rising edge: requests go in, poses get checked.
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) sb.note_request(req_ang);
      if (!reset && rsp_valid && rsp_ready) sb.check_pose(rsp_pos, rsp_rot);
   end

   // Receiver: its own stall pattern (runs of ready and of stall), plus the
   // long hold-off when asked for.
   initial begin
      int run;
      @(negedge clock);
      while (1) begin
         run = $urandom_range(1, 12);
         case ($urandom_range(0, 3))
            0: begin
               rsp_ready <= 0;
               repeat (run) @(negedge clock);
            end
            default: begin
               rsp_ready <= !long_stall;
               repeat (run) @(negedge clock);
            end
         endcase
         while (long_stall) begin
            rsp_ready <= 0;
            @(negedge clock);
         end
      end
   end

   // Register write; only called with the pipe drained. Leaves csr_valid low
   // before returning so back-to-back writes never collide.
   task automatic write_reg(logic [dhfk_pkg::CSR_INDEX_W-1:0] idx, logic [15:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == dhfk_pkg::CSR_SCALE) sb.scale = val;
      else if (idx == dhfk_pkg::CSR_JOINTS) sb.joints = val[2:0];
      @(negedge clock);
      csr_valid <= 0;
      @(negedge clock);
   endtask

   // Offer one request and hold it until accepted; stays at the negedge after.
   task automatic send_pose(logic signed [17:0] ang [6]);
      req_valid <= 1;
      for (int i = 0; i < 6; i++) req_ang[i] <= ang[i];
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drop_valid();
      req_valid <= 0;
   endtask

   // Wait for every pose to come back, plus pipeline latency margin.
   task automatic drain();
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   function automatic logic signed [17:0] rand_angle(int mode);
      case (mode)
         0: return 18'($urandom_range(0, 205888)) - 18'sd102944;
         1: return 18'($urandom());                // full 18-bit range, wraps
         default: return 18'($urandom_range(0, 3000)) - 18'sd1500;  // near zero
      endcase
   endfunction

   // Random stream in bursts, with gaps between some of them.
   task automatic random_poses(int count);
      logic signed [17:0] a [6];
      int left, burst;
      left = count;
      while (left > 0) begin
         burst = $urandom_range(1, 20);
         if (burst > left) burst = left;
         for (int b = 0; b < burst; b++) begin
            for (int i = 0; i < 6; i++) a[i] = rand_angle($urandom_range(0, 5) == 0 ? 1 :
                                                         ($urandom_range(0, 5) == 0 ? 2 : 0));
            send_pose(a);
         end
         left -= burst;
         if ($urandom_range(0, 2) != 0) begin
            drop_valid();
            repeat ($urandom_range(1, 15)) @(negedge clock);
         end
      end
      drop_valid();
   endtask

   // Stimulus
   initial begin
      logic signed [17:0] a [6];
      logic signed [17:0] corner [10];
      logic [15:0] scales [5];
      logic [2:0] counts [6];
      corner = '{18'sd0, 18'sd102944, -18'sd102944, 18'sd131071, -18'sd131072,
                 18'sd51472, -18'sd51472, 18'sd25736, 18'sd25737, 18'sd1};
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // Directed: reset settings, field extremes, quarter and half turns,
      // angles beyond two pi.
      for (int k = 0; k < 10; k++) begin
         for (int i = 0; i < 6; i++) a[i] = corner[(k + i) % 10];
         send_pose(a);
      end
      for (int i = 0; i < 6; i++) a[i] = -18'sd1;
      send_pose(a);
      drop_valid();
      drain();

      // joint_count zero and above the max, plus extreme scales
      write_reg(dhfk_pkg::CSR_JOINTS, 16'd0);
      write_reg(dhfk_pkg::CSR_SCALE, 16'hFFFF);
      for (int i = 0; i < 6; i++) a[i] = 18'sd0;
      send_pose(a);
      a = '{18'sd131071, -18'sd131072, 18'sd102944, 18'sd0, 18'sd0, 18'sd0};
      send_pose(a);
      drop_valid();
      drain();
      write_reg(dhfk_pkg::CSR_JOINTS, 16'd7);
      send_pose(a);
      for (int i = 0; i < 6; i++) a[i] = 18'sd51472;
      send_pose(a);
      drop_valid();
      drain();
      write_reg(dhfk_pkg::CSR_SCALE, 16'd0);
      send_pose(a);
      drop_valid();
      drain();
      // unknown register index is ignored
      write_reg(2'd3, 16'h1234);
      send_pose(a);
      drop_valid();
      drain();

      // Backpressure: receiver holds off while the sender keeps offering.
      write_reg(dhfk_pkg::CSR_SCALE, 16'd4096);
      write_reg(dhfk_pkg::CSR_JOINTS, 16'd6);
      long_stall = 1;
      fork
         random_poses(60);
         begin
            repeat (300) @(negedge clock);
            long_stall = 0;
         end
      join
      drain();

      // Random phases over several register settings
      scales = '{16'd4096, 16'hFFFF, 16'd0, 16'd1, 16'd20000};
      counts = '{3'd1, 3'd6, 3'd2, 3'd3, 3'd4, 3'd5};
      for (int ph = 0; ph < 8; ph++) begin
         write_reg(dhfk_pkg::CSR_SCALE, ph < 5 ? scales[ph] : 16'($urandom()));
         write_reg(dhfk_pkg::CSR_JOINTS,
                   ph < 6 ? 16'(counts[ph]) : 16'($urandom_range(0, 7)));
         random_poses(210);
         drain();
      end

      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #5ms;
      $display("[FAIL] regression broken");
      $finish;
   end
endmodule

@@ sim.f @@
design/dhfk_pkg.sv
design/dhfk_cordic.sv
design/dhfk_link.sv
design/dh_forward_kinematics_6dof_core.sv
tb/sv/tb_dh_forward_kinematics_6dof_core.sv
